// File: hdl/qlu_pkg.sv
package qlu_pkg;

	// Table geometry. The state and action counts are powers of two, so an
	// entry address is the state index with the action index appended.
	localparam int NUM_STATES  = 1024;
	localparam int NUM_ACTIONS = 8;
	localparam int STATE_W     = $clog2(NUM_STATES);
	localparam int ACT_W       = $clog2(NUM_ACTIONS);
	localparam int COUNT_W     = ACT_W + 1;
	localparam int TAB_AW      = STATE_W + ACT_W;

	localparam int VAL_W  = 32;
	localparam int RATE_W = 17;
	localparam int ACC_W  = VAL_W + ACT_W;

	localparam logic [RATE_W-1:0] RATE_ONE       = 17'd65536;
	localparam logic [RATE_W-1:0] LEARN_RATE_RST = 17'd6554;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [RATE_W-1:0]       rate_t;

	typedef enum logic [1:0] {
		REG_LEARN_RATE = 2'd0,
		REG_DISCOUNT   = 2'd1,
		REG_INIT_VALUE = 2'd2,
		REG_BDP_MODE   = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_S,
		ST_RD_NS,
		ST_DECIDE,
		ST_FILL_S,
		ST_FILL_NS,
		ST_SCAN,
		ST_RD_OLD,
		ST_MUL_G,
		ST_DELTA,
		ST_MUL_A,
		ST_FINISH
	} qlu_state_t;

	typedef struct packed {
		logic              we;
		logic [TAB_AW-1:0] waddr;
		value_t            wdata;
		logic [TAB_AW-1:0] raddr;
	} tab_req_t;

	typedef struct packed {
		logic               we;
		logic [STATE_W-1:0] waddr;
		logic               wdata;
		logic [STATE_W-1:0] raddr;
	} seen_req_t;

	typedef struct packed {
		logic             issue;
		logic [ACT_W-1:0] idx;
		logic             sum_mode;
		logic             want_min;
	} scan_ctl_t;

	typedef struct packed {
		logic ld_g;
		logic ld_delta;
		logic ld_a;
		logic bootstrap;
	} upd_ctl_t;

	function automatic rate_t clamp_rate(input rate_t r);
		return (r > RATE_ONE) ? RATE_ONE : r;
	endfunction

endpackage

// File: hdl/q_learning_table_update_core.sv
// Channel   Beat moves                          Payload
// s_axis    one transition (s, a, r, s')        s_axis_tdata, 80 bits
// m_axis    one update result                   m_axis_tdata, 72 bits
// cfg       one register write                  cfg_addr, cfg_data
//
// Transitions are worked one at a time, from accept to the next accept: the
// successor actions are scanned (1 to 8 of them), after a fill of eight entries
// for each newly seen state. The single read port of the value table, one entry
// per cycle, and the two chained multiply stages bound how fast that goes.
// After reset a clearing pass zeroes the seen flags; s_axis_tready stays low
// during it while configuration writes are taken as usual.
// The result sits in an output register, so the next transition is accepted while
// it waits; a finished update stalls only when that register is still full.
module q_learning_table_update_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [9:0] cur_state, [12:10] cur_action, [44:13] reward, [54:45] next_state,
	// [58:55] next_action_count, [59] next_done, [60] termination_override,
	// [61] discount_override, [78:62] step_discount, [79] next_player
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] updated_value, [63:32] next_value, [66:64] best_next_action,
	// [67] saturated, [71:68] zero
	output logic [71:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data
);
	import qlu_pkg::*;

	// Configuration registers.
	rate_t  learn_rate_q;
	rate_t  discount_q;
	value_t init_value_q;
	logic   bdp_mode_q;

	// The transition being worked on.
	logic [STATE_W-1:0] s_q;
	logic [ACT_W-1:0]   a_q;
	value_t             reward_q;
	logic [STATE_W-1:0] ns_q;
	logic [COUNT_W-1:0] cnt_lim_q;
	logic               done_q;
	logic               term_ovr_q;
	rate_t              gamma_q;
	logic               player_q;

	qlu_state_t         state_q;
	qlu_state_t         state_d;
	logic [ACT_W-1:0]   cnt_q;
	logic [STATE_W-1:0] clr_q;
	logic               seen_s_q;
	logic               fill_ns_q;
	logic               m_valid_q;
	logic [71:0]        m_data_q;

	tab_req_t           tab_req;
	seen_req_t          seen_req;
	scan_ctl_t          scan_ctl;
	upd_ctl_t           upd_ctl;
	value_t             tab_rdata;
	logic               seen_rdata;
	logic signed [ACC_W-1:0] acc;
	logic [ACT_W-1:0]   best;
	value_t             next_value;
	value_t             new_value;
	logic               saturated;

	logic               in_ready;
	logic               in_beat;
	logic               out_load;
	logic               fill_end;
	logic               scan_end;
	logic               fill_ns;
	logic               sum_mode;
	logic               want_min;
	logic [3:0]         cnt_raw;
	logic [COUNT_W-1:0] cnt_lim_c;

	assign sum_mode = bdp_mode_q & player_q;
	assign want_min = bdp_mode_q | player_q;
	assign fill_end = (cnt_q == ACT_W'(NUM_ACTIONS-1));
	assign scan_end = (COUNT_W'(cnt_q) == cnt_lim_q - COUNT_W'(1));
	// A successor equal to the current state is already filled by then.
	assign fill_ns  = !seen_rdata && (ns_q != s_q);
	assign in_beat  = s_axis_tvalid && in_ready;

	// An action count of zero means one; counts above the table width saturate.
	assign cnt_raw = s_axis_tdata[58:55];
	always_comb begin
		if (cnt_raw == 4'd0) begin
			cnt_lim_c = COUNT_W'(1);
		end else if (cnt_raw > 4'(NUM_ACTIONS)) begin
			cnt_lim_c = COUNT_W'(NUM_ACTIONS);
		end else begin
			cnt_lim_c = COUNT_W'(cnt_raw);
		end
	end

	// Configuration writes are always taken; software must write only while idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= LEARN_RATE_RST;
			discount_q   <= RATE_ONE;
			init_value_q <= '0;
			bdp_mode_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_LEARN_RATE: learn_rate_q <= cfg_data[RATE_W-1:0];
				REG_DISCOUNT:   discount_q   <= cfg_data[RATE_W-1:0];
				REG_INIT_VALUE: init_value_q <= cfg_data;
				REG_BDP_MODE:   bdp_mode_q   <= cfg_data[0];
			endcase
		end
	end

	// Capture a transition. The discount is chosen and clamped here; software must
	// keep the registers unchanged while one is in flight, as the block does not check.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			s_q        <= s_axis_tdata[STATE_W-1:0];
			a_q        <= s_axis_tdata[10 +: ACT_W];
			reward_q   <= s_axis_tdata[44:13];
			ns_q       <= s_axis_tdata[45 +: STATE_W];
			cnt_lim_q  <= cnt_lim_c;
			done_q     <= s_axis_tdata[59];
			term_ovr_q <= s_axis_tdata[60];
			gamma_q    <= s_axis_tdata[61] ? clamp_rate(s_axis_tdata[78:62])
			                                : clamp_rate(discount_q);
			player_q   <= s_axis_tdata[79];
		end
		if (state_q == ST_RD_NS) begin
			seen_s_q <= seen_rdata;
		end
		if (state_q == ST_DECIDE) begin
			fill_ns_q <= fill_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + STATE_W'(1);
			end
			if (state_q == ST_DECIDE) begin
				cnt_q <= '0;
			end else if (state_q == ST_FILL_S || state_q == ST_FILL_NS) begin
				cnt_q <= fill_end ? '0 : cnt_q + ACT_W'(1);
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + ACT_W'(1);
			end
		end
	end

	// Sequencer: clearing pass, seen lookups, fills, successor scan, old value read, the
	// arithmetic stages, and the write-back together with the result.
	always_comb begin
		state_d            = state_q;
		tab_req            = '0;
		tab_req.waddr      = {s_q, cnt_q};
		tab_req.wdata      = init_value_q;
		tab_req.raddr      = {ns_q, cnt_q};
		seen_req           = '0;
		seen_req.waddr     = s_q;
		seen_req.wdata     = 1'b1;
		seen_req.raddr     = s_q;
		scan_ctl           = '0;
		scan_ctl.idx       = cnt_q;
		scan_ctl.sum_mode  = sum_mode;
		scan_ctl.want_min  = want_min;
		upd_ctl            = '0;
		upd_ctl.bootstrap  = !done_q || term_ovr_q;
		in_ready           = 1'b0;
		out_load           = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				seen_req.we    = 1'b1;
				seen_req.waddr = clr_q;
				seen_req.wdata = 1'b0;
				if (clr_q == STATE_W'(NUM_STATES-1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_RD_S;
				end
			end
			ST_RD_S: begin
				state_d = ST_RD_NS;
			end
			ST_RD_NS: begin
				seen_req.raddr = ns_q;
				state_d        = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!seen_s_q) begin
					state_d = ST_FILL_S;
				end else if (fill_ns) begin
					state_d = ST_FILL_NS;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_FILL_S: begin
				tab_req.we  = 1'b1;
				seen_req.we = 1'b1;
				if (fill_end) begin
					state_d = fill_ns_q ? ST_FILL_NS : ST_SCAN;
				end
			end
			ST_FILL_NS: begin
				tab_req.we     = 1'b1;
				tab_req.waddr  = {ns_q, cnt_q};
				tab_req.wdata  = done_q ? '0 : init_value_q;
				seen_req.we    = 1'b1;
				seen_req.waddr = ns_q;
				if (fill_end) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_ctl.issue = 1'b1;
				if (scan_end) begin
					state_d = ST_RD_OLD;
				end
			end
			ST_RD_OLD: begin
				tab_req.raddr = {s_q, a_q};
				state_d       = ST_MUL_G;
			end
			ST_MUL_G: begin
				upd_ctl.ld_g = 1'b1;
				state_d      = ST_DELTA;
			end
			ST_DELTA: begin
				upd_ctl.ld_delta = 1'b1;
				state_d          = ST_MUL_A;
			end
			ST_MUL_A: begin
				upd_ctl.ld_a = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_valid_q || m_axis_tready) begin
					tab_req.we    = 1'b1;
					tab_req.waddr = {s_q, a_q};
					tab_req.wdata = new_value;
					out_load      = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	qlu_store u_store (
		.clk        (clk),
		.tab_req    (tab_req),
		.tab_rdata  (tab_rdata),
		.seen_req   (seen_req),
		.seen_rdata (seen_rdata)
	);

	qlu_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.rdata  (tab_rdata),
		.acc    (acc),
		.best   (best)
	);

	qlu_update u_update (
		.clk        (clk),
		.ctl        (upd_ctl),
		.acc        (acc),
		.sum_mode   (sum_mode),
		.gamma      (gamma_q),
		.alpha      (clamp_rate(learn_rate_q)),
		.reward     (reward_q),
		.old_value  (tab_rdata),
		.next_value (next_value),
		.new_value  (new_value),
		.saturated  (saturated)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {4'b0000, saturated, best, next_value, new_value};
		end
	end

	assign s_axis_tready = in_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// File: hdl/qlu_store.sv
module qlu_store (
	input  logic                clk,
	input  qlu_pkg::tab_req_t  tab_req,
	output qlu_pkg::value_t    tab_rdata,
	input  qlu_pkg::seen_req_t seen_req,
	output logic                seen_rdata
);
	import qlu_pkg::*;

	// Value table: one write and one registered read per cycle.
	value_t value_table [NUM_STATES*NUM_ACTIONS];
	// Seen flags: cleared by a sweep from the controller after reset.
	logic   state_seen  [NUM_STATES];

	value_t tab_rdata_q;
	logic   seen_rdata_q;

	always_ff @(posedge clk) begin
		if (tab_req.we) begin
			value_table[tab_req.waddr] <= tab_req.wdata;
		end
		tab_rdata_q <= value_table[tab_req.raddr];
	end

	always_ff @(posedge clk) begin
		if (seen_req.we) begin
			state_seen[seen_req.waddr] <= seen_req.wdata;
		end
		seen_rdata_q <= state_seen[seen_req.raddr];
	end

	assign tab_rdata  = tab_rdata_q;
	assign seen_rdata = seen_rdata_q;

endmodule

// File: hdl/qlu_scan.sv
module qlu_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qlu_pkg::scan_ctl_t               ctl,
	input  qlu_pkg::value_t                  rdata,
	output logic signed [qlu_pkg::ACC_W-1:0] acc,
	output logic [qlu_pkg::ACT_W-1:0]        best
);
	import qlu_pkg::*;

	logic                    valid_s1;
	logic [ACT_W-1:0]        idx_s1;
	logic                    sum_mode_s1;
	logic                    want_min_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic [ACT_W-1:0]        best_q;
	logic signed [ACC_W-1:0] rdata_ext;
	value_t                  acc_val;
	logic                    take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1      <= ctl.idx;
		sum_mode_s1 <= ctl.sum_mode;
		want_min_s1 <= ctl.want_min;
	end

	// Entries arrive in the cycle after their address was issued. Strict
	// compares keep the lowest index on a tie.
	always_comb begin
		rdata_ext = ACC_W'(rdata);
		acc_val   = acc_q[VAL_W-1:0];
		if (want_min_s1) begin
			take = (rdata < acc_val);
		end else begin
			take = (rdata > acc_val);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (idx_s1 == '0) begin
				acc_q  <= rdata_ext;
				best_q <= '0;
			end else if (sum_mode_s1) begin
				acc_q <= acc_q + rdata_ext;
			end else if (take) begin
				acc_q  <= rdata_ext;
				best_q <= idx_s1;
			end
		end
	end

	assign acc  = acc_q;
	assign best = best_q;

endmodule

// File: hdl/qlu_update.sv
module qlu_update (
	input  logic                              clk,
	input  qlu_pkg::upd_ctl_t                ctl,
	input  logic signed [qlu_pkg::ACC_W-1:0] acc,
	input  logic                              sum_mode,
	input  qlu_pkg::rate_t                   gamma,
	input  qlu_pkg::rate_t                   alpha,
	input  qlu_pkg::value_t                  reward,
	input  qlu_pkg::value_t                  old_value,
	output qlu_pkg::value_t                  next_value,
	output qlu_pkg::value_t                  new_value,
	output logic                              saturated
);
	import qlu_pkg::*;

	localparam int PG_W = VAL_W + RATE_W + 1;
	localparam int RG_W = PG_W - 16;
	localparam int TG_W = RG_W + 1;
	localparam int DL_W = TG_W + 1;
	localparam int PA_W = DL_W + RATE_W + 1;
	localparam int RA_W = PA_W - 16;
	localparam int NV_W = RA_W + 1;

	localparam value_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam value_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	value_t                 vnext_c;
	logic                   sum_clamp_c;
	logic signed [PG_W-1:0] rnd_g_full;
	logic signed [RG_W-1:0] rnd_g;
	logic signed [TG_W-1:0] target;
	logic signed [PA_W-1:0] rnd_a_full;
	logic signed [RA_W-1:0] rnd_a;
	logic signed [NV_W-1:0] nv_full;
	logic                   nv_clamp;

	value_t                 vnext_s1;
	logic                   sum_sat_s1;
	value_t                 old_s1;
	logic signed [PG_W-1:0] prod_g_s1;
	logic signed [DL_W-1:0] delta_s2;
	logic signed [PA_W-1:0] prod_a_s3;

	// Bootstrap value: the chosen entry, or in sum mode the sum of entries clamped to 32 bits.
	always_comb begin
		sum_clamp_c = 1'b0;
		vnext_c     = acc[VAL_W-1:0];
		if (sum_mode && (acc[ACC_W-1:VAL_W-1] != '0) && (acc[ACC_W-1:VAL_W-1] != '1)) begin
			sum_clamp_c = 1'b1;
			vnext_c     = acc[ACC_W-1] ? VAL_MIN : VAL_MAX;
		end
	end

	// Rounding to nearest with halves up is an arithmetic shift of p + 1/2.
	always_comb begin
		rnd_g_full = prod_g_s1 + PG_W'(32768);
		rnd_g      = rnd_g_full[PG_W-1:16];
		target     = TG_W'(reward) + (ctl.bootstrap ? TG_W'(rnd_g) : TG_W'(0));
		rnd_a_full = prod_a_s3 + PA_W'(32768);
		rnd_a      = rnd_a_full[PA_W-1:16];
		nv_full    = NV_W'(old_s1) + NV_W'(rnd_a);
		nv_clamp   = (nv_full[NV_W-1:VAL_W-1] != '0) && (nv_full[NV_W-1:VAL_W-1] != '1);
		if (nv_clamp) begin
			new_value = nv_full[NV_W-1] ? VAL_MIN : VAL_MAX;
		end else begin
			new_value = nv_full[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_g) begin
			vnext_s1   <= vnext_c;
			sum_sat_s1 <= sum_clamp_c;
			old_s1     <= old_value;
			prod_g_s1  <= PG_W'($signed({1'b0, gamma})) * PG_W'(vnext_c);
		end
		if (ctl.ld_delta) begin
			delta_s2 <= DL_W'(target) - DL_W'(old_s1);
		end
		if (ctl.ld_a) begin
			prod_a_s3 <= PA_W'($signed({1'b0, alpha})) * PA_W'(delta_s2);
		end
	end

	assign next_value = vnext_s1;
	assign saturated  = sum_sat_s1 | nv_clamp;

endmodule

// File: hdl/qlu_port_checker.sv
module qlu_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] pending_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// Transitions taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// Every result beat answers a transition that was taken in.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pending_q != 2'd0)
		else $error("result beat without an outstanding transition");

	// At most one transition in work and one result waiting.
	a_bounded_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two transitions outstanding");

	// Transitions are worked one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_axis_tready)
		else $error("input ready right after an accepted transition");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

endmodule

bind q_learning_table_update_core qlu_port_checker u_port_checker (.*);
